### sv/assert_macros.svh
// Assertion macros shared by the slot tracker RTL.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define CST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define CST_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cst_pkg.sv
// Types and constants of the command slot tracker.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package cst_pkg;

    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 5;
    localparam int WORD_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STICKY_BIT = 30;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC    = 2'd0,
        MODE_RELEASE  = 2'd1,
        MODE_ISSUE    = 2'd2,
        MODE_COMPLETE = 2'd3
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_GRANTED   = 3'd0,
        KIND_NONE_FREE = 3'd1,
        KIND_RELEASED  = 3'd2,
        KIND_REL_ERROR = 3'd3,
        KIND_ISSUED    = 3'd4,
        KIND_COMPLETED = 3'd5,
        KIND_NONE_DONE = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_SINGLE,
        ST_CMPL
    } t_state;

endpackage

### sv/cst_cmd_if.sv
// Request channel of the slot tracker: valid/ready plus one request beat.
// Depends on cst_pkg for field widths.
`timescale 1ns / 1ps

interface cst_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [cst_pkg::MODE_W-1:0]  mode;
    logic [cst_pkg::SLOT_W-1:0]  slot;
    logic [cst_pkg::WORD_W-1:0]  owner_id;
    logic [cst_pkg::WORD_W-1:0]  busy_mask;
    logic [cst_pkg::WORD_W-1:0]  port_status;

    modport source (output valid, mode, slot, owner_id, busy_mask, port_status,
                    input ready);
    modport sink   (input valid, mode, slot, owner_id, busy_mask, port_status,
                    output ready);
endinterface

### sv/cst_res_if.sv
// Result channel of the slot tracker: valid/ready plus one result beat.
// Depends on cst_pkg for field widths.
`timescale 1ns / 1ps

interface cst_res_if;
    logic                        valid;
    logic                        ready;
    logic [cst_pkg::KIND_W-1:0]  kind;
    logic [cst_pkg::SLOT_W-1:0]  slot_res;
    logic [cst_pkg::WORD_W-1:0]  owner_id_res;
    logic [cst_pkg::WORD_W-1:0]  saved_status;
    logic                        last;

    modport source (output valid, kind, slot_res, owner_id_res, saved_status, last,
                    input ready);
    modport sink   (input valid, kind, slot_res, owner_id_res, saved_status, last,
                    output ready);
endinterface

### sv/command_slot_tracker.sv
// Command slot tracker top level: slot state, sequencer and result register.
// Depends on cst_pkg, cst_cmd_if, cst_res_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Tracks SLOT_COUNT command slots (allocated bit, active bit, owner id) and
// one saved port status word. A request beat is taken only while the block
// is idle, and one slot index walker then visits one slot per cycle while
// no result beat is held up by a stalled consumer. Allocate accepts, then
// walks up to the lowest free slot; release and issue act on one slot; a
// completion event visits slots up to the highest completed one, emitting
// one result beat per completed slot, lowest first, with last set on the
// final one, or one none-done beat if none did. A result beat waits in an
// output register, so a stalled consumer holds the walk only when the next
// beat is ready to go out. Status bit 30, once saved, sticks until reset.
// Reset clears all slot bits at once; owner ids need no clearing.
module command_slot_tracker #(
    parameter int SLOT_COUNT = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    cst_cmd_if.sink    i_cmd,
    cst_res_if.source  o_res
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
    localparam logic [cst_pkg::SLOT_W:0] SLOT_LIMIT = (cst_pkg::SLOT_W + 1)'(SLOT_COUNT);

    // Sequencer and captured request
    cst_pkg::t_state                r_state, n_state;
    cst_pkg::t_mode                 r_mode;
    logic [cst_pkg::SLOT_W-1:0]     r_slot;
    logic [cst_pkg::WORD_W-1:0]     r_owner_in;
    logic [IW-1:0]                  r_idx, n_idx;
    logic [SLOT_COUNT-1:0]          r_done, n_done;

    // Slot state
    logic [SLOT_COUNT-1:0]          r_alloc, n_alloc;
    logic [SLOT_COUNT-1:0]          r_active, n_active;
    logic [cst_pkg::WORD_W-1:0]     r_owner [SLOT_COUNT];
    logic [cst_pkg::WORD_W-1:0]     r_status, n_status;

    // Result register
    logic                           r_out_valid;
    cst_pkg::t_kind                 r_kind;
    logic [cst_pkg::SLOT_W-1:0]     r_slot_res;
    logic [cst_pkg::WORD_W-1:0]     r_owner_res;
    logic [cst_pkg::WORD_W-1:0]     r_saved;
    logic                           r_last;

    // Walker outputs
    logic                           w_accept;
    logic                           w_out_free;
    logic                           w_slot_ok;
    logic [IW-1:0]                  w_slot_idx;
    logic [SLOT_COUNT-1:0]          w_idx_bit;
    logic [SLOT_COUNT-1:0]          w_done_rest;
    logic                           w_load;
    cst_pkg::t_kind                 w_kind;
    logic [cst_pkg::SLOT_W-1:0]     w_slot_res;
    logic [cst_pkg::WORD_W-1:0]     w_owner_res;
    logic [cst_pkg::WORD_W-1:0]     w_saved;
    logic                           w_last;
    logic                           w_owner_we;

    assign i_cmd.ready = (r_state == cst_pkg::ST_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_slot_ok   = ({1'b0, r_slot} < SLOT_LIMIT);
    assign w_slot_idx  = r_slot[IW-1:0];
    assign w_idx_bit   = {{(SLOT_COUNT-1){1'b0}}, 1'b1} << r_idx;
    assign w_done_rest = r_done & ~w_idx_bit;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cst_pkg::ST_IDLE;
            r_idx    <= '0;
            r_done   <= '0;
            r_alloc  <= '0;
            r_active <= '0;
            r_status <= '0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_done   <= n_done;
            r_alloc  <= n_alloc;
            r_active <= n_active;
            r_status <= n_status;
        end
    end

    // Capture the request beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode     <= cst_pkg::t_mode'(i_cmd.mode);
            r_slot     <= i_cmd.slot;
            r_owner_in <= i_cmd.owner_id;
        end
    end

    // Record the owner on issue
    always_ff @(posedge i_clk) begin
        if (w_owner_we) begin
            r_owner[w_slot_idx] <= r_owner_in;
        end
    end

    // Sequence the walk and build the next result beat
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_done      = r_done;
        n_alloc     = r_alloc;
        n_active    = r_active;
        n_status    = r_status;
        w_load      = 1'b0;
        w_kind      = cst_pkg::KIND_GRANTED;
        w_slot_res  = '0;
        w_owner_res = '0;
        w_saved     = '0;
        w_last      = 1'b1;
        w_owner_we  = 1'b0;

        case (r_state)
            cst_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_idx = '0;
                    case (cst_pkg::t_mode'(i_cmd.mode))
                        cst_pkg::MODE_ALLOC: begin
                            n_state = cst_pkg::ST_ALLOC;
                        end
                        cst_pkg::MODE_RELEASE, cst_pkg::MODE_ISSUE: begin
                            n_state = cst_pkg::ST_SINGLE;
                        end
                        cst_pkg::MODE_COMPLETE: begin
                            n_state = cst_pkg::ST_CMPL;
                            n_done  = r_active & ~i_cmd.busy_mask[SLOT_COUNT-1:0];
                            if (!r_status[cst_pkg::STICKY_BIT]) begin
                                n_status = i_cmd.port_status;
                            end
                        end
                        default: begin
                            n_state = cst_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // Walk up to the lowest free slot
            cst_pkg::ST_ALLOC: begin
                if (!r_alloc[r_idx]) begin
                    if (w_out_free) begin
                        w_load         = 1'b1;
                        w_kind         = cst_pkg::KIND_GRANTED;
                        w_slot_res     = cst_pkg::SLOT_W'(r_idx);
                        n_alloc[r_idx] = 1'b1;
                        n_state        = cst_pkg::ST_IDLE;
                    end
                end else if (r_idx == LAST_IDX) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        w_kind  = cst_pkg::KIND_NONE_FREE;
                        n_state = cst_pkg::ST_IDLE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // Release or issue one slot
            cst_pkg::ST_SINGLE: begin
                case (r_mode)
                    cst_pkg::MODE_RELEASE: begin
                        if (w_out_free) begin
                            w_load     = 1'b1;
                            w_slot_res = r_slot;
                            n_state    = cst_pkg::ST_IDLE;
                            if (w_slot_ok && r_alloc[w_slot_idx]) begin
                                w_kind              = cst_pkg::KIND_RELEASED;
                                n_alloc[w_slot_idx] = 1'b0;
                            end else begin
                                w_kind = cst_pkg::KIND_REL_ERROR;
                            end
                        end
                    end
                    cst_pkg::MODE_ISSUE: begin
                        if (!w_slot_ok) begin
                            // drop an issue beyond the slot range silently
                            n_state = cst_pkg::ST_IDLE;
                        end else if (w_out_free) begin
                            w_load               = 1'b1;
                            w_kind               = cst_pkg::KIND_ISSUED;
                            w_slot_res           = r_slot;
                            n_active[w_slot_idx] = 1'b1;
                            w_owner_we           = 1'b1;
                            n_state              = cst_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        n_state = cst_pkg::ST_IDLE;
                    end
                endcase
            end

            // Emit completed slots lowest first, or one none-done beat if none completed
            cst_pkg::ST_CMPL: begin
                if (r_done == '0) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        w_kind  = cst_pkg::KIND_NONE_DONE;
                        w_saved = r_status;
                        n_state = cst_pkg::ST_IDLE;
                    end
                end else if (r_done[r_idx]) begin
                    if (w_out_free) begin
                        w_load          = 1'b1;
                        w_kind          = cst_pkg::KIND_COMPLETED;
                        w_slot_res      = cst_pkg::SLOT_W'(r_idx);
                        w_owner_res     = r_owner[r_idx];
                        w_saved         = r_status;
                        w_last          = (w_done_rest == '0);
                        n_done          = w_done_rest;
                        n_active[r_idx] = 1'b0;
                        if (w_done_rest == '0) begin
                            n_state = cst_pkg::ST_IDLE;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            default: begin
                n_state = cst_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind      <= w_kind;
            r_slot_res  <= w_slot_res;
            r_owner_res <= w_owner_res;
            r_saved     <= w_saved;
            r_last      <= w_last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_kind;
    assign o_res.slot_res     = r_slot_res;
    assign o_res.owner_id_res = r_owner_res;
    assign o_res.saved_status = r_saved;
    assign o_res.last         = r_last;

    // Checks on the slot bookkeeping
    `CST_ASSERT_NXT(a_sticky_holds, r_status[cst_pkg::STICKY_BIT], r_status[cst_pkg::STICKY_BIT], "sticky status bit dropped")
    `CST_ASSERT_IMP(a_done_active, r_state == cst_pkg::ST_CMPL, (r_done & ~r_active) == '0, "pending completion on an inactive slot")
    `CST_ASSERT_IMP(a_none_free_full, w_load && (w_kind == cst_pkg::KIND_NONE_FREE), &r_alloc, "none free reported with a free slot")
    `CST_ASSERT_NXT(a_last_to_idle, w_load && w_last, r_state == cst_pkg::ST_IDLE, "final beat did not end the request")

endmodule

### dv/tb_command_slot_tracker.sv
// Self-checking testbench for command_slot_tracker: random-gap request and result
// channels, a slot-state scoreboard class and a cycle limit.
// Depends on cst_pkg, cst_cmd_if, cst_res_if and the tracker RTL.
`timescale 1ns / 1ps

module tb_command_slot_tracker;

    localparam int SLOTS        = 32;
    localparam int RANDOM_ITEMS = 230;
    localparam int STALL_CYCLES = 200;
    localparam int TAIL_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SLOT_W       = cst_pkg::SLOT_W;
    localparam int WORD_W       = cst_pkg::WORD_W;
    localparam int STICKY_BIT   = cst_pkg::STICKY_BIT;
    localparam logic [WORD_W-1:0] STICKY_MASK = 32'h1 << STICKY_BIT;

    typedef struct packed {
        cst_pkg::t_mode     mode;
        logic [SLOT_W-1:0]  slot;
        logic [WORD_W-1:0]  owner_id;
        logic [WORD_W-1:0]  busy_mask;
        logic [WORD_W-1:0]  port_status;
    } t_slot_req;

    typedef struct packed {
        cst_pkg::t_kind     kind;
        logic [SLOT_W-1:0]  slot_res;
        logic [WORD_W-1:0]  owner_id_res;
        logic [WORD_W-1:0]  saved_status;
        logic               last;
    } t_slot_res;

    // Mirror of the slot table; predicts the result beats of each request
    class slot_scoreboard;
        bit                slot_alloc [SLOTS];
        bit                slot_busy  [SLOTS];
        logic [WORD_W-1:0] slot_owner [SLOTS];
        logic [WORD_W-1:0] status_word;
        t_slot_res         awaited [$];
        int                errors;
        int                beats_checked;
        int                kind_hits [7];

        function new();
            foreach (slot_alloc[s]) begin
                slot_alloc[s] = 1'b0;
                slot_busy[s]  = 1'b0;
                slot_owner[s] = '0;
            end
            status_word   = '0;
            errors        = 0;
            beats_checked = 0;
            foreach (kind_hits[k]) kind_hits[k] = 0;
        endfunction

        function void push(cst_pkg::t_kind kind, int slot, logic [WORD_W-1:0] owner,
                           logic [WORD_W-1:0] status, logic last);
            t_slot_res r;
            r.kind         = kind;
            r.slot_res     = slot[SLOT_W-1:0];
            r.owner_id_res = owner;
            r.saved_status = status;
            r.last         = last;
            awaited.push_back(r);
        endfunction

        // Update the mirror with one accepted request and queue its results
        function void note_request(t_slot_req q);
            int  found;
            int  n_done;
            int  k;
            found = -1;
            case (q.mode)
                cst_pkg::MODE_ALLOC: begin
                    for (int s = 0; s < SLOTS; s++)
                        if (found < 0 && !slot_alloc[s]) found = s;
                    if (found >= 0) begin
                        slot_alloc[found] = 1'b1;
                        push(cst_pkg::KIND_GRANTED, found, '0, '0, 1'b1);
                    end else begin
                        push(cst_pkg::KIND_NONE_FREE, 0, '0, '0, 1'b1);
                    end
                end
                cst_pkg::MODE_RELEASE: begin
                    if (int'(q.slot) < SLOTS && slot_alloc[q.slot]) begin
                        slot_alloc[q.slot] = 1'b0;
                        push(cst_pkg::KIND_RELEASED, int'(q.slot), '0, '0, 1'b1);
                    end else begin
                        push(cst_pkg::KIND_REL_ERROR, int'(q.slot), '0, '0, 1'b1);
                    end
                end
                cst_pkg::MODE_ISSUE: begin
                    if (int'(q.slot) < SLOTS) begin
                        slot_busy[q.slot]  = 1'b1;
                        slot_owner[q.slot] = q.owner_id;
                        push(cst_pkg::KIND_ISSUED, int'(q.slot), '0, '0, 1'b1);
                    end
                end
                default: begin
                    // Keep a stored error word; otherwise take the new status
                    if (!status_word[STICKY_BIT]) status_word = q.port_status;
                    n_done = 0;
                    for (int s = 0; s < SLOTS; s++)
                        if (slot_busy[s] && !q.busy_mask[s]) n_done++;
                    if (n_done == 0) begin
                        push(cst_pkg::KIND_NONE_DONE, 0, '0, status_word, 1'b1);
                    end else begin
                        k = 0;
                        for (int s = 0; s < SLOTS; s++) begin
                            if (slot_busy[s] && !q.busy_mask[s]) begin
                                slot_busy[s] = 1'b0;
                                k++;
                                push(cst_pkg::KIND_COMPLETED, s, slot_owner[s],
                                     status_word, k == n_done);
                            end
                        end
                    end
                end
            endcase
        endfunction

        function bit field_ok(string name, logic [WORD_W-1:0] exp_v,
                              logic [WORD_W-1:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: mismatch on %s: expected %h, actual %h",
                         $time, name, exp_v, act_v);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        // Compare one accepted result beat with the oldest prediction
        function void check_result(t_slot_res r);
            t_slot_res e;
            bit        ok;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result beat: actual kind %0d slot %0d",
                         $time, r.kind, r.slot_res);
                errors++;
                return;
            end
            e  = awaited.pop_front();
            ok = field_ok("kind", 32'(e.kind), 32'(r.kind));
            ok = field_ok("slot_res", 32'(e.slot_res), 32'(r.slot_res)) && ok;
            ok = field_ok("owner_id_res", e.owner_id_res, r.owner_id_res) && ok;
            ok = field_ok("saved_status", e.saved_status, r.saved_status) && ok;
            ok = field_ok("last", 32'(e.last), 32'(r.last)) && ok;
            if (!ok) errors++;
            beats_checked++;
            if (int'(e.kind) < 7) kind_hits[e.kind]++;
        endfunction

        function int free_count();
            int n;
            n = 0;
            foreach (slot_alloc[s]) if (!slot_alloc[s]) n++;
            return n;
        endfunction

        // Random slot whose allocated bit equals want, or -1 if there is none
        function int pick_slot(bit want);
            int cands [$];
            foreach (slot_alloc[s]) if (slot_alloc[s] == want) cands.push_back(s);
            if (cands.size() == 0) return -1;
            return cands[$urandom_range(0, cands.size() - 1)];
        endfunction

        function logic [WORD_W-1:0] active_mask();
            logic [WORD_W-1:0] m;
            m = '0;
            foreach (slot_busy[s]) m[s] = slot_busy[s];
            return m;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cst_cmd_if cmd_bus ();
    cst_res_if res_bus ();

    command_slot_tracker #(
        .SLOT_COUNT (SLOTS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    slot_scoreboard sb = new();

    bit idle_on    = 1'b1;
    bit stall_req  = 1'b0;
    int reqs_sent  = 0;
    int cycles     = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, sb.awaited.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Record each accepted request beat
    always @(posedge i_clk) begin
        t_slot_req q;
        if (i_rst_n && cmd_bus.valid && cmd_bus.ready) begin
            q.mode        = cst_pkg::t_mode'(cmd_bus.mode);
            q.slot        = cmd_bus.slot;
            q.owner_id    = cmd_bus.owner_id;
            q.busy_mask   = cmd_bus.busy_mask;
            q.port_status = cmd_bus.port_status;
            sb.note_request(q);
        end
    end

    // Check each accepted result beat
    always @(posedge i_clk) begin
        t_slot_res r;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            r.kind         = cst_pkg::t_kind'(res_bus.kind);
            r.slot_res     = res_bus.slot_res;
            r.owner_id_res = res_bus.owner_id_res;
            r.saved_status = res_bus.saved_status;
            r.last         = res_bus.last;
            sb.check_result(r);
        end
    end

    // Result sink: random gap before each beat, one long hold on request
    initial begin : result_sink
        int gap;
        res_bus.ready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            gap = idle_on ? $urandom_range(0, 7) : 0;
            if (stall_req) begin
                gap       = STALL_CYCLES;
                stall_req = 1'b0;
            end
            if (gap > 0) begin
                res_bus.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_bus.valid && res_bus.ready));
            @(negedge i_clk);
        end
    end

    // Offer one request beat after a random gap; return at the next falling edge
    task automatic send_req(cst_pkg::t_mode mode, logic [SLOT_W-1:0] slot,
                            logic [WORD_W-1:0] owner, logic [WORD_W-1:0] busy,
                            logic [WORD_W-1:0] pstat);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.mode        <= mode;
        cmd_bus.slot        <= slot;
        cmd_bus.owner_id    <= owner;
        cmd_bus.busy_mask   <= busy;
        cmd_bus.port_status <= pstat;
        do @(posedge i_clk); while (!(cmd_bus.valid && cmd_bus.ready));
        @(negedge i_clk);
        reqs_sent++;
    endtask

    // Status word with the sticky error bit clear, so later saves stay visible
    function automatic logic [WORD_W-1:0] calm_status();
        return $urandom() & ~STICKY_MASK;
    endfunction

    // Random slot field for requests that ignore it
    function automatic logic [SLOT_W-1:0] rand_slot();
        return SLOT_W'($urandom());
    endfunction

    // Make every slot active, then complete all of them in one event
    task automatic issue_all_and_complete();
        for (int s = 0; s < SLOTS; s++)
            send_req(cst_pkg::MODE_ISSUE, s[SLOT_W-1:0], $urandom(), $urandom(),
                     calm_status());
        send_req(cst_pkg::MODE_COMPLETE, rand_slot(), $urandom(), '0, calm_status());
    endtask

    initial begin : stimulus
        int                pick;
        int                slot_pick;
        int                n_rel;
        int                rand_base;
        int                next_flip;
        int                fills;
        int                bursts;
        bit                stall_done;
        logic [WORD_W-1:0] mask;

        fills      = 0;
        bursts     = 0;
        stall_done = 1'b0;

        cmd_bus.valid       = 1'b0;
        cmd_bus.mode        = cst_pkg::MODE_ALLOC;
        cmd_bus.slot        = '0;
        cmd_bus.owner_id    = '0;
        cmd_bus.busy_mask   = '0;
        cmd_bus.port_status = '0;

        // Reset
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty table, grants, overwrites, releases, field extremes
        send_req(cst_pkg::MODE_COMPLETE, 5'd0, '0, '1, '0);
        send_req(cst_pkg::MODE_RELEASE, 5'd0, '0, '0, '0);
        send_req(cst_pkg::MODE_ALLOC, 5'd31, '1, '1, '1);
        send_req(cst_pkg::MODE_ALLOC, 5'd0, '0, '0, '0);
        send_req(cst_pkg::MODE_ISSUE, 5'd0, 32'hFFFF_FFFF, '1, '1);
        send_req(cst_pkg::MODE_ISSUE, 5'd31, 32'h0000_0000, '0, '0);
        send_req(cst_pkg::MODE_ISSUE, 5'd1, 32'hA5A5_A5A5, '0, '0);
        send_req(cst_pkg::MODE_ISSUE, 5'd1, 32'h1234_5678, '0, '0);
        send_req(cst_pkg::MODE_RELEASE, 5'd0, '1, '1, '1);
        send_req(cst_pkg::MODE_RELEASE, 5'd31, '0, '0, '0);
        send_req(cst_pkg::MODE_COMPLETE, 5'd31, '1, 32'h7FFF_FFFF, 32'hBFFF_FFFF);
        send_req(cst_pkg::MODE_COMPLETE, 5'd0, '0, 32'h0000_0000, 32'h0000_0000);
        send_req(cst_pkg::MODE_COMPLETE, 5'd0, '0, 32'h0000_0000, 32'hBFFF_FFFF);
        send_req(cst_pkg::MODE_ALLOC, 5'd0, '0, '0, '0);
        send_req(cst_pkg::MODE_ALLOC, 5'd0, '0, '0, '0);
        send_req(cst_pkg::MODE_ISSUE, 5'd2, 32'h8000_0001, '0, '0);
        send_req(cst_pkg::MODE_COMPLETE, 5'd0, '0, 32'hFFFF_FFFB, 32'h8000_0000);
        send_req(cst_pkg::MODE_RELEASE, 5'd1, '0, '0, '0);
        send_req(cst_pkg::MODE_RELEASE, 5'd0, '0, '0, '0);
        send_req(cst_pkg::MODE_RELEASE, 5'd2, '0, '0, '0);

        // Random sequences, mostly well formed
        rand_base = reqs_sent;
        next_flip = reqs_sent;
        while (reqs_sent - rand_base < RANDOM_ITEMS) begin
            // Switch idle gaps on or off at random for each stretch of requests
            if (reqs_sent >= next_flip) begin
                idle_on   = ($urandom_range(0, 3) != 0);
                next_flip = reqs_sent + 30;
            end

            // Hold the sink off for a long stretch while a full burst goes in
            if (!stall_done && reqs_sent - rand_base >= 100) begin
                stall_done = 1'b1;
                stall_req  = 1'b1;
                issue_all_and_complete();
                continue;
            end

            pick = $urandom_range(0, 11);
            if (pick == 9 && fills >= 3) pick = 2;
            if (pick == 10 && bursts >= 1) pick = 5;
            case (pick)
                2, 3, 4: begin
                    // Allocate then issue an allocated slot
                    if (sb.free_count() > 0)
                        send_req(cst_pkg::MODE_ALLOC, rand_slot(), $urandom(), $urandom(),
                                 calm_status());
                    slot_pick = sb.pick_slot(1'b1);
                    if (slot_pick >= 0)
                        send_req(cst_pkg::MODE_ISSUE, slot_pick[SLOT_W-1:0], $urandom(),
                                 $urandom(), calm_status());
                end
                5, 6: begin
                    // Completion: random busy bits over the active slots
                    mask = sb.active_mask();
                    if ($urandom_range(0, 1) != 0)
                        send_req(cst_pkg::MODE_COMPLETE, rand_slot(), $urandom(),
                                 ($urandom() & mask) | ~mask, calm_status());
                    else
                        send_req(cst_pkg::MODE_COMPLETE, rand_slot(), $urandom(),
                                 $urandom(), calm_status());
                end
                7, 8: begin
                    // Release, mostly of an allocated slot
                    slot_pick = ($urandom_range(0, 3) != 0) ? sb.pick_slot(1'b1) : -1;
                    if (slot_pick < 0) slot_pick = $urandom_range(0, SLOTS - 1);
                    send_req(cst_pkg::MODE_RELEASE, slot_pick[SLOT_W-1:0], $urandom(),
                             $urandom(), calm_status());
                end
                9: begin
                    // Fill the table, ask once more, then free a few slots
                    fills++;
                    while (sb.free_count() > 0)
                        send_req(cst_pkg::MODE_ALLOC, rand_slot(), $urandom(), $urandom(),
                                 calm_status());
                    send_req(cst_pkg::MODE_ALLOC, rand_slot(), $urandom(), $urandom(),
                             calm_status());
                    n_rel = $urandom_range(4, 12);
                    repeat (n_rel) begin
                        slot_pick = sb.pick_slot(1'b1);
                        if (slot_pick >= 0)
                            send_req(cst_pkg::MODE_RELEASE, slot_pick[SLOT_W-1:0],
                                     $urandom(), $urandom(), calm_status());
                    end
                end
                10: begin
                    bursts++;
                    issue_all_and_complete();
                end
                default: begin
                    // Noise: any mode with random content
                    send_req(cst_pkg::t_mode'($urandom_range(0, 3)), rand_slot(),
                             $urandom(), $urandom(), calm_status());
                end
            endcase
        end

        // Sticky error: set bit 30, then show that later events keep the word
        idle_on = 1'b1;
        send_req(cst_pkg::MODE_ISSUE, 5'd7, 32'h0BAD_F00D, '0, '0);
        send_req(cst_pkg::MODE_COMPLETE, 5'd0, '0, '1, 32'h4000_0000);
        send_req(cst_pkg::MODE_COMPLETE, 5'd0, '0, '0, 32'h1234_5678);
        send_req(cst_pkg::MODE_ISSUE, 5'd30, 32'h5555_AAAA, '0, '0);
        send_req(cst_pkg::MODE_COMPLETE, 5'd0, '0, 32'hBFFF_FFFF, '1);
        send_req(cst_pkg::MODE_COMPLETE, 5'd0, '0, '0, $urandom());
        cmd_bus.valid <= 1'b0;

        // Drain, then allow the block's latency for any stray beat
        while (sb.awaited.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests and %0d result beats: %0d grants, %0d none free,",
                 reqs_sent, sb.beats_checked, sb.kind_hits[cst_pkg::KIND_GRANTED],
                 sb.kind_hits[cst_pkg::KIND_NONE_FREE]);
        $display("  %0d release errors, %0d slots completed, %0d empty completions.",
                 sb.kind_hits[cst_pkg::KIND_REL_ERROR],
                 sb.kind_hits[cst_pkg::KIND_COMPLETED],
                 sb.kind_hits[cst_pkg::KIND_NONE_DONE]);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
